>>> design/efcb_pkg.sv
// efcb_pkg: shared types, frame constants and byte selection helpers
// used by the frame builder, its channel interfaces and its checker
package efcb_pkg;

    localparam logic [7:0]  FRAME_START  = 8'hAA;
    localparam logic [7:0]  FRAME_END    = 8'hDD;
    localparam logic [7:0]  OP_CONTROL   = 8'h02;
    localparam logic [7:0]  OP_KEEPALIVE = 8'h19;
    localparam logic [4:0]  CONTROL_LEN  = 5'd15;
    localparam logic [4:0]  KEEPALIVE_LEN = 5'd1;
    localparam logic [15:0] CRC_PRESET   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    localparam int CMD_W      = 1;
    localparam int THROTTLE_W = 16;
    localparam int BYTE_W     = 8;

    localparam logic KIND_CONTROL   = 1'b0;
    localparam logic KIND_KEEPALIVE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_BYTE = 4'b0010,
        ST_CRC  = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    function automatic logic [4:0] payload_len(input logic kind);
        logic [4:0] len;
        len = (kind == KIND_KEEPALIVE) ? KEEPALIVE_LEN : CONTROL_LEN;
        return len;
    endfunction

    function automatic logic [7:0] payload_byte(input logic kind,
                                                input logic [15:0] thr,
                                                input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (kind == KIND_KEEPALIVE) begin
            b = OP_KEEPALIVE;
        end
        else begin
            case (idx)
                4'd0:    b = OP_CONTROL;
                4'd3:    b = thr[15:8];
                4'd4:    b = thr[7:0];
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

>>> design/efcb_cmd_if.sv
// efcb_cmd_if: command channel, valid/ready with cmd and throttle payload
// depends on efcb_pkg for field widths
interface efcb_cmd_if import efcb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [THROTTLE_W-1:0] throttle;

    modport source (output valid, output cmd, output throttle, input ready);
    modport sink   (input valid, input cmd, input throttle, output ready);
endinterface

>>> design/efcb_frame_if.sv
// efcb_frame_if: frame byte channel, valid/ready with frame_byte and last
// depends on efcb_pkg for field widths
interface efcb_frame_if import efcb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

>>> design/esc_command_frame_builder.sv
// esc_command_frame_builder: turns one command transaction into a serial frame
// of bytes: start 0xAA, length, payload, Modbus CRC-16 (high byte first), end 0xDD.
// Channels: command (sink, cmd + throttle) and frame (source, frame_byte + last).
// One command is taken at a time; command.ready is high only while idle.
// Each frame byte is selected in ST_BYTE and then held in an output register
// until frame.ready takes it. Payload bytes also pass bit-serially through the
// CRC shift register in ST_CRC, one bit per cycle, before they are offered.
// Each byte then waits in ST_SEND for as long as the receiver stalls.
// Control frame: 20 bytes, 15 payload.
// Keep-alive frame: 6 bytes, 1 payload.
// Between frames it returns to idle, where command.ready is high and the next
// command is taken; its first byte then passes through ST_BYTE to ST_SEND.
// The bit-serial CRC shifter sets the pace.
// last is high on the end byte of every frame.
// Reset (rst_n low, asynchronous) returns to idle at once, drops frame.valid and
// holds command.ready high; a frame in progress is abandoned.
// A stalled receiver holds the byte and last stable until it is taken.
// depends on efcb_pkg, efcb_cmd_if, efcb_frame_if
module esc_command_frame_builder
    import efcb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    efcb_cmd_if.sink      command,
    efcb_frame_if.source  frame
);

    state_t      state_reg,   state_next;
    logic [4:0]  pos_reg,     pos_next;
    logic [15:0] crc_reg,     crc_next;
    logic        kind_reg,    kind_next;
    logic [15:0] thr_reg,     thr_next;
    logic [7:0]  byte_reg,    byte_next;
    logic [7:0]  shift_reg,   shift_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        last_reg,    last_next;

    logic [4:0]  len;
    logic [4:0]  pay_idx;
    logic        is_payload;
    logic [7:0]  cur_byte;
    logic        fb;

    assign command.ready    = (state_reg == ST_IDLE);
    assign frame.valid      = (state_reg == ST_SEND);
    assign frame.frame_byte = byte_reg;
    assign frame.last       = last_reg;

    assign len        = payload_len(kind_reg);
    assign pay_idx    = pos_reg - 5'd2;
    assign is_payload = (pos_reg >= 5'd2) && (pos_reg <= len + 5'd1);
    assign fb         = crc_reg[0] ^ shift_reg[0];

    always_comb
    begin
        cur_byte = FRAME_END;
        if (pos_reg == 5'd0) begin
            cur_byte = FRAME_START;
        end
        else if (pos_reg == 5'd1) begin
            cur_byte = {3'b000, len};
        end
        else if (is_payload) begin
            cur_byte = payload_byte(kind_reg, thr_reg, pay_idx[3:0]);
        end
        else if (pos_reg == len + 5'd2) begin
            cur_byte = crc_reg[15:8];
        end
        else if (pos_reg == len + 5'd3) begin
            cur_byte = crc_reg[7:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        kind_next    = kind_reg;
        thr_next     = thr_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (command.valid) begin
                    kind_next  = command.cmd[0];
                    thr_next   = command.throttle;
                    pos_next   = 5'd0;
                    crc_next   = CRC_PRESET;
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE:
            begin
                byte_next    = cur_byte;
                shift_next   = cur_byte;
                last_next    = (pos_reg == len + 5'd4);
                bit_cnt_next = 3'd0;
                state_next   = is_payload ? ST_CRC : ST_SEND;
            end
            ST_CRC:
            begin
                // one crc bit per cycle, lsb first
                crc_next     = {1'b0, crc_reg[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
                shift_next   = {1'b0, shift_reg[7:1]};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (frame.ready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end
                    else begin
                        pos_next   = pos_reg + 5'd1;
                        state_next = ST_BYTE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 5'd0;
            crc_reg     <= CRC_PRESET;
            kind_reg    <= KIND_CONTROL;
            thr_reg     <= 16'h0000;
            bit_cnt_reg <= 3'd0;
            last_reg    <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            kind_reg    <= kind_next;
            thr_reg     <= thr_next;
            bit_cnt_reg <= bit_cnt_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        shift_reg <= shift_next;
    end

endmodule

>>> design/efcb_checker.sv
// efcb_checker: port-level assertions for the frame builder, bound into esc_command_frame_builder
// depends on efcb_pkg and esc_command_frame_builder
module efcb_checker
    import efcb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        frm_valid,
    input logic        frm_ready,
    input logic [7:0]  frm_byte,
    input logic        frm_last
);

    // a stalled frame transaction holds its byte
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && !frm_ready |=> frm_valid && $stable(frm_byte) && $stable(frm_last))
        else $error("frame byte changed while stalled");

    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && frm_last |-> frm_byte == FRAME_END)
        else $error("last flag not on end byte");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while a frame is in progress");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid |-> !cmd_ready)
        else $error("command channel open while a frame byte is pending");

    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && frm_ready && frm_last |=> cmd_ready && !frm_valid)
        else $error("not idle after end of frame");

endmodule

bind esc_command_frame_builder efcb_checker u_efcb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (command.valid),
    .cmd_ready (command.ready),
    .frm_valid (frame.valid),
    .frm_ready (frame.ready),
    .frm_byte  (frame.frame_byte),
    .frm_last  (frame.last)
);
